// File: src/swk_pkg.sv
// Package with shared types, constants and the CORDIC arctangent table.
package swk_pkg;

   localparam int CordicIterations = 16;
   localparam int MaxIter = 24;

   localparam int AngW = 28;   // Q.24 angle with headroom
   localparam int VecW = 40;   // Q.16 vector components with headroom

   localparam logic signed [AngW-1:0] PiQ24     = 28'sd52707179;
   localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
   localparam logic [15:0] GainQ16 = 16'd39797;
   localparam logic [15:0] Cos45Q16 = 16'd46341;
   localparam logic signed [15:0] AngleLimit = 16'sd25736;

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] heading;
      logic signed [15:0] yaw_rate;
   } req_type;

   typedef struct packed {
      logic [1:0]         wheel_index;
      logic signed [15:0] steer_angle;
      logic [15:0]        wheel_speed;
      logic               last;
   } rsp_type;

   function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] i);
      logic signed [AngW-1:0] r;
      begin
         case (i)
            5'd0: r = 28'sd13176795;
            5'd1: r = 28'sd7778716;
            5'd2: r = 28'sd4110060;
            5'd3: r = 28'sd2086331;
            5'd4: r = 28'sd1047214;
            5'd5: r = 28'sd524117;
            5'd6: r = 28'sd262123;
            5'd7: r = 28'sd131069;
            default: begin
               if (i < 5'd24) begin
                  r = 28'sd65536 >>> (i - 5'd8);
               end else begin
                  r = '0;
               end
            end
         endcase
         return r;
      end
   endfunction

endpackage

// File: src/swk_rotate_stage.sv
// One registered CORDIC step, rotation or vectoring mode, with a stall enable.
module swk_rotate_stage #(
   parameter int Step = 0,
   parameter bit Vectoring = 1'b0,
   parameter int TagW = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               valid_in,
   input  logic signed [swk_pkg::VecW-1:0]    x_in_d,
   input  logic signed [swk_pkg::VecW-1:0]    y_in_d,
   input  logic signed [swk_pkg::AngW-1:0]    z_in_d,
   input  logic [TagW-1:0]                    tag_in_d,
   output logic                               valid_out,
   output logic signed [swk_pkg::VecW-1:0]    x_out,
   output logic signed [swk_pkg::VecW-1:0]    y_out,
   output logic signed [swk_pkg::AngW-1:0]    z_out,
   output logic [TagW-1:0]                    tag_out
);

   logic                            valid_ff;
   logic signed [swk_pkg::VecW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [swk_pkg::AngW-1:0] z_ff, z_in;
   logic [TagW-1:0]                 tag_ff;
   logic                            cw;

   // Direction choice: vectoring drives y to zero, rotation drives z to zero.
   always_comb begin
      cw = Vectoring ? (y_in_d >= 0) : (z_in_d < 0);
      if (cw) begin
         x_in = x_in_d + (y_in_d >>> Step);
         y_in = y_in_d - (x_in_d >>> Step);
         z_in = Vectoring ? z_in_d + swk_pkg::atan_q24(5'(Step))
                          : z_in_d + swk_pkg::atan_q24(5'(Step));
      end else begin
         x_in = x_in_d - (y_in_d >>> Step);
         y_in = y_in_d + (x_in_d >>> Step);
         z_in = z_in_d - swk_pkg::atan_q24(5'(Step));
      end
   end

   // Stage registers advance only when the pipe moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= tag_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign tag_out   = tag_ff;

endmodule

// File: src/swk_front.sv
// Front end: heading reduction, translation CORDIC, rotation vector and wheel serializer.
module swk_front #(
   parameter int Iterations = swk_pkg::CordicIterations
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic [11:0]                     arm_length,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  swk_pkg::req_type                req_data,
   output logic                            wv_valid,
   output logic signed [swk_pkg::VecW-1:0] wv_x,
   output logic signed [swk_pkg::VecW-1:0] wv_y,
   output logic [1:0]                      wv_wheel
);

   localparam int N = (Iterations > swk_pkg::MaxIter) ? swk_pkg::MaxIter : Iterations;
   localparam int VW = swk_pkg::VecW;
   localparam int AW = swk_pkg::AngW;
   localparam int TW = 29;   // rotation magnitude product sign and value

   // Stage 0: reduce heading, start vector, yaw times arm.
   logic                  s0_valid_ff;
   logic signed [VW-1:0]  s0_x_ff, s0_x_in;
   logic signed [AW-1:0]  s0_z_ff, s0_z_in;
   logic signed [TW-1:0]  s0_r_ff, s0_r_in;
   logic                  adv0;

   always_comb begin
      s0_z_in = AW'(req_data.heading) <<< 11;
      s0_x_in = VW'(req_data.speed) * $signed({1'b0, swk_pkg::GainQ16});
      if (s0_z_in > swk_pkg::HalfPiQ24) begin
         s0_z_in = s0_z_in - swk_pkg::PiQ24;
         s0_x_in = -s0_x_in;
      end else if (s0_z_in < -swk_pkg::HalfPiQ24) begin
         s0_z_in = s0_z_in + swk_pkg::PiQ24;
         s0_x_in = -s0_x_in;
      end
      s0_r_in = TW'(req_data.yaw_rate) * $signed({1'b0, arm_length});
   end

   // Serializer holds an item while it steps through the four wheels, so the front pipe accepts when it moves.
   logic       ser_busy;
   assign adv0 = enable && !ser_busy;
   assign req_ready = adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv0) begin
         s0_valid_ff <= req_valid;
      end
      if (adv0) begin
         s0_x_ff <= s0_x_in;
         s0_z_ff <= s0_z_in;
         s0_r_ff <= s0_r_in;
      end
   end

   // Translation CORDIC chain; rotation product rides along as tag.
   logic                 cv   [0:N];
   logic signed [VW-1:0] cx   [0:N];
   logic signed [VW-1:0] cy   [0:N];
   logic signed [AW-1:0] cz   [0:N];
   logic [TW-1:0]        ct   [0:N];

   assign cv[0] = s0_valid_ff;
   assign cx[0] = s0_x_ff;
   assign cy[0] = '0;
   assign cz[0] = s0_z_ff;
   assign ct[0] = s0_r_ff;

   for (genvar g = 0; g < N; g++) begin : g_rot
      swk_rotate_stage #(.Step(g), .Vectoring(1'b0), .TagW(TW)) u_stage (
         .clock(clock), .reset(reset), .enable(adv0),
         .valid_in(cv[g]), .x_in_d(cx[g]), .y_in_d(cy[g]), .z_in_d(cz[g]),
         .tag_in_d(ct[g]),
         .valid_out(cv[g+1]), .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1]),
         .tag_out(ct[g+1])
      );
   end

   // Rotation component: |r|*16*cos45 rounded, registered with the translation.
   logic                 s1_valid_ff;
   logic signed [VW-1:0] s1_tx_ff, s1_ty_ff;
   logic [31:0]          s1_rc_ff, s1_rc_in;
   logic                 s1_neg_ff;
   logic [TW-1:0]        rmag;
   logic [48:0]          rprod;

   always_comb begin
      rmag = ct[N][TW-1] ? TW'(-$signed(ct[N])) : ct[N];
      rprod = 49'({rmag, 4'b0}) * 49'(swk_pkg::Cos45Q16) + 49'd32768;
      s1_rc_in = 32'(rprod >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv0) begin
         s1_valid_ff <= cv[N];
      end
      if (adv0) begin
         s1_tx_ff  <= cx[N];
         s1_ty_ff  <= cy[N];
         s1_rc_ff  <= s1_rc_in;
         s1_neg_ff <= ct[N][TW-1];
      end
   end

   // Wheel serializer: one wheel vector per cycle while the pipe is enabled, four per request.
   logic                 ser_valid_ff;
   logic [1:0]           ser_wheel_ff;
   logic signed [VW-1:0] ser_tx_ff, ser_ty_ff;
   logic [31:0]          ser_rc_ff;
   logic                 ser_neg_ff;
   logic                 take;

   assign ser_busy = ser_valid_ff && (ser_wheel_ff != 2'd3);
   assign take = adv0 && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_wheel_ff <= '0;
      end else if (enable) begin
         if (ser_busy) begin
            ser_wheel_ff <= ser_wheel_ff + 2'd1;
         end else begin
            ser_valid_ff <= s1_valid_ff;
            ser_wheel_ff <= '0;
         end
      end
      if (take) begin
         ser_tx_ff  <= s1_tx_ff;
         ser_ty_ff  <= s1_ty_ff;
         ser_rc_ff  <= s1_rc_ff;
         ser_neg_ff <= s1_neg_ff;
      end
   end

   // Per-wheel signs: x negative for wheels 0 and 3, y negative for wheels 2 and 3.
   logic cneg, sneg;
   logic signed [VW-1:0] rcs;
   always_comb begin
      cneg = ser_neg_ff ^ (ser_wheel_ff == 2'd0 || ser_wheel_ff == 2'd3);
      sneg = ser_neg_ff ^ ser_wheel_ff[1];
      rcs  = VW'({1'b0, ser_rc_ff});
      wv_x = cneg ? ser_tx_ff - rcs : ser_tx_ff + rcs;
      wv_y = sneg ? ser_ty_ff - rcs : ser_ty_ff + rcs;
   end

   assign wv_valid = ser_valid_ff;
   assign wv_wheel = ser_wheel_ff;

endmodule

// File: src/swk_back.sv
// Back end: vectoring CORDIC per wheel, then angle rounding and speed scaling.
module swk_back #(
   parameter int Iterations = swk_pkg::CordicIterations
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            wv_valid,
   input  logic signed [swk_pkg::VecW-1:0] wv_x,
   input  logic signed [swk_pkg::VecW-1:0] wv_y,
   input  logic [1:0]                      wv_wheel,
   output logic                            out_valid,
   output swk_pkg::rsp_type                out_data
);

   localparam int N = (Iterations > swk_pkg::MaxIter) ? swk_pkg::MaxIter : Iterations;
   localparam int VW = swk_pkg::VecW;
   localparam int AW = swk_pkg::AngW;
   localparam int TW = 3;   // wheel index and zero flag

   // Stage 0: fold the left half plane, flag the zero vector.
   logic                 s0_valid_ff;
   logic signed [VW-1:0] s0_x_ff, s0_y_ff, s0_x_in, s0_y_in;
   logic signed [AW-1:0] s0_z_ff, s0_z_in;
   logic [TW-1:0]        s0_t_ff;

   always_comb begin
      s0_x_in = wv_x;
      s0_y_in = wv_y;
      s0_z_in = '0;
      if (wv_x < 0) begin
         s0_z_in = (wv_y >= 0) ? swk_pkg::PiQ24 : -swk_pkg::PiQ24;
         s0_x_in = -wv_x;
         s0_y_in = -wv_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= wv_valid;
      end
      if (enable) begin
         s0_x_ff <= s0_x_in;
         s0_y_ff <= s0_y_in;
         s0_z_ff <= s0_z_in;
         s0_t_ff <= {(wv_x == 0) && (wv_y == 0), wv_wheel};
      end
   end

   logic                 cv [0:N];
   logic signed [VW-1:0] cx [0:N];
   logic signed [VW-1:0] cy [0:N];
   logic signed [AW-1:0] cz [0:N];
   logic [TW-1:0]        ct [0:N];

   assign cv[0] = s0_valid_ff;
   assign cx[0] = s0_x_ff;
   assign cy[0] = s0_y_ff;
   assign cz[0] = s0_z_ff;
   assign ct[0] = s0_t_ff;

   for (genvar g = 0; g < N; g++) begin : g_vec
      swk_rotate_stage #(.Step(g), .Vectoring(1'b1), .TagW(TW)) u_stage (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(cv[g]), .x_in_d(cx[g]), .y_in_d(cy[g]), .z_in_d(cz[g]),
         .tag_in_d(ct[g]),
         .valid_out(cv[g+1]), .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1]),
         .tag_out(ct[g+1])
      );
   end

   // Speed multiply by the gain, registered before rounding.
   logic                 m_valid_ff;
   logic [VW+15:0]       m_prod_ff;
   logic signed [AW-1:0] m_z_ff;
   logic [TW-1:0]        m_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (enable) begin
         m_valid_ff <= cv[N];
      end
      if (enable) begin
         m_prod_ff <= (VW+16)'(cx[N][VW-2:0]) * (VW+16)'(swk_pkg::GainQ16);
         m_z_ff    <= cz[N];
         m_t_ff    <= ct[N];
      end
   end

   // Rounding, clamping and the zero-vector case.
   logic [VW+15:0]       mr;
   logic signed [AW-1:0] ar;
   logic signed [15:0]   ang;
   logic [15:0]          spd;
   swk_pkg::rsp_type     o_in, o_ff;
   logic                 o_valid_ff;

   always_comb begin
      mr = (m_prod_ff + (VW+16)'(64'h8000_0000)) >> 32;
      spd = (mr > (VW+16)'(65535)) ? 16'hFFFF : mr[15:0];
      ar = (m_z_ff + AW'(1024)) >>> 11;
      if (ar > AW'(swk_pkg::AngleLimit)) begin
         ang = swk_pkg::AngleLimit;
      end else if (ar < -AW'(swk_pkg::AngleLimit)) begin
         ang = -swk_pkg::AngleLimit;
      end else begin
         ang = ar[15:0];
      end
      o_in.wheel_index = m_t_ff[1:0];
      o_in.steer_angle = m_t_ff[2] ? '0 : ang;
      o_in.wheel_speed = m_t_ff[2] ? '0 : spd;
      o_in.last        = (m_t_ff[1:0] == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (enable) begin
         o_valid_ff <= m_valid_ff;
      end
      if (enable) begin
         o_ff <= o_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_ff;

endmodule

// File: src/swerve_wheel_kinematics_unit.sv
// Top level of the four-wheel swerve inverse kinematics pipeline.
// Throughput: one wheel result per cycle while the output is not stalled, four wheel results per request.
// The whole pipeline stalls together while the output holds an untaken result.
// Synchronous active-high reset empties the pipe and sets arm_length to 256.
module swerve_wheel_kinematics_unit #(
   parameter int CORDIC_ITERATIONS = swk_pkg::CordicIterations
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [11:0]      csr_write_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  swk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output swk_pkg::rsp_type rsp_data
);

   logic [11:0] arm_length_ff;
   logic        enable;
   logic        wv_valid;
   logic signed [swk_pkg::VecW-1:0] wv_x, wv_y;
   logic [1:0]  wv_wheel;

   // Arm length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_length_ff <= 12'd256;
      end else if (csr_write_enable) begin
         arm_length_ff <= csr_write_data;
      end
   end

   // The pipe moves when the output slot is empty or being taken.
   assign enable = !rsp_valid || rsp_ready;

   swk_front #(.Iterations(CORDIC_ITERATIONS)) u_front (
      .clock(clock), .reset(reset), .enable(enable), .arm_length(arm_length_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .wv_valid(wv_valid), .wv_x(wv_x), .wv_y(wv_y), .wv_wheel(wv_wheel)
   );

   swk_back #(.Iterations(CORDIC_ITERATIONS)) u_back (
      .clock(clock), .reset(reset), .enable(enable),
      .wv_valid(wv_valid), .wv_x(wv_x), .wv_y(wv_y), .wv_wheel(wv_wheel),
      .out_valid(rsp_valid), .out_data(rsp_data)
   );

endmodule

// File: test/swk_checker.sv
// Checker that predicts the four wheel results of each request and compares them.
module swk_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [11:0]      csr_write_data,
   input  logic             req_valid,
   input  logic             req_ready,
   input  swk_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  swk_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PiL = 52707179;
   localparam longint HalfPiL = 26353589;
   localparam longint GainL = 39797;
   localparam longint Cos45L = 46341;
   localparam longint LimitL = 25736;

   logic             [11:0] arm_len;
   swk_pkg::rsp_type wheel_queue[$];

   // Arctangent table entry in Q.24.
   function automatic longint atan_entry(input int i);
      longint t[8] = '{13176795, 7778716, 4110060, 2086331,
                       1047214, 524117, 262123, 131069};
      if (i < 8) return t[i];
      return longint'(65536) >>> (i - 8);
   endfunction

   // Vectoring pass that yields the steering angle and the wheel speed of one wheel.
   function automatic swk_pkg::rsp_type solve_wheel(input longint x, input longint y,
                                                    input int k);
      swk_pkg::rsp_type res;
      longint  z, xs, ys, a, m;
      z = 0;
      res.wheel_index = k[1:0];
      res.last = (k == 3);
      if (x == 0 && y == 0) begin
         res.steer_angle = '0;
         res.wheel_speed = '0;
         return res;
      end
      if (x < 0) begin
         z = (y >= 0) ? PiL : -PiL;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < swk_pkg::CordicIterations; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z += atan_entry(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z -= atan_entry(i);
         end
      end
      a = (z + 1024) >>> 11;
      if (a > LimitL) a = LimitL;
      if (a < -LimitL) a = -LimitL;
      m = (x * GainL + (longint'(1) << 31)) >>> 32;
      if (m > 65535) m = 65535;
      if (m < 0) m = 0;
      res.steer_angle = a[15:0];
      res.wheel_speed = m[15:0];
      return res;
   endfunction

   // Translation rotation plus per-wheel rotation vectors; queues four wheel results.
   task automatic predict_wheels(input swk_pkg::req_type rq);
      longint tx, ty, h, xs, ys, r, rc, cx, cy;
      bit     rneg;
      bit     cneg[4] = '{1, 0, 0, 1};
      bit     sneg[4] = '{0, 0, 1, 1};
      h = longint'(rq.heading) * 2048;
      tx = longint'(rq.speed) * GainL;
      ty = 0;
      if (h > HalfPiL) begin
         h -= PiL;
         tx = -tx;
      end else if (h < -HalfPiL) begin
         h += PiL;
         tx = -tx;
      end
      for (int i = 0; i < swk_pkg::CordicIterations; i++) begin
         xs = tx >>> i;
         ys = ty >>> i;
         if (h >= 0) begin
            tx = tx - ys;
            ty = ty + xs;
            h -= atan_entry(i);
         end else begin
            tx = tx + ys;
            ty = ty - xs;
            h += atan_entry(i);
         end
      end
      r = longint'(rq.yaw_rate) * longint'(arm_len) * 16;
      rneg = r < 0;
      if (rneg) r = -r;
      rc = (r * Cos45L + 32768) >>> 16;
      for (int k = 0; k < 4; k++) begin
         cx = (rneg ^ cneg[k]) ? -rc : rc;
         cy = (rneg ^ sneg[k]) ? -rc : rc;
         wheel_queue.push_back(solve_wheel(tx + cx, ty + cy, k));
      end
   endtask

   // Watch all three ports at the rising edge.
   always @(posedge clock) begin
      swk_pkg::rsp_type want;
      if (reset) begin
         arm_len <= 12'd256;
      end else begin
         if (csr_write_enable) arm_len <= csr_write_data;
         if (req_valid && req_ready) predict_wheels(req_data);
         if (rsp_valid && rsp_ready) begin
            if (wheel_queue.size() == 0) begin
               $error("unexpected wheel result %p", rsp_data);
               fail_count++;
            end else begin
               want = wheel_queue.pop_front();
               if (rsp_data.wheel_index !== want.wheel_index) begin
                  $error("wheel_index expected %0d actual %0d",
                         want.wheel_index, rsp_data.wheel_index);
                  fail_count++;
               end
               if (rsp_data.steer_angle !== want.steer_angle) begin
                  $error("steer_angle expected %0d actual %0d",
                         want.steer_angle, rsp_data.steer_angle);
                  fail_count++;
               end
               if (rsp_data.wheel_speed !== want.wheel_speed) begin
                  $error("wheel_speed expected %0d actual %0d",
                         want.wheel_speed, rsp_data.wheel_speed);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = wheel_queue.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end
endmodule

// File: test/tb_swerve_wheel_kinematics_unit.sv
// Testbench top: drives chassis commands and arm length settings, gives the verdict.
module tb_swerve_wheel_kinematics_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 2 * swk_pkg::CordicIterations + 20;
   localparam longint CycleLimit = 400000;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [11:0]      csr_write_data;
   logic             req_valid;
   logic             req_ready;
   swk_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   swk_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending_count;
   longint           cycle_count;
   int               request_total;
   int               arm_settings;

   swerve_wheel_kinematics_unit DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   swk_checker checker_inst (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length: mostly short, sometimes long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Stall pattern on the result side.
   initial begin
      int g;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Global timeout.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("swerve_wheel_kinematics_unit test failed");
            $finish;
         end
      end
   end

   // Send one request and wait until it is taken. Valid drops only ahead of a gap,
   // so back-to-back requests keep it high with a fresh payload.
   task automatic send_command(input logic [15:0] spd, input logic [15:0] hdg,
                               input logic [15:0] yaw, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_data <= '{speed: spd, heading: hdg, yaw_rate: yaw};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      request_total++;
   endtask

   // Stop sending and let the pipe drain before touching the register.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (Latency) @(negedge clock);
   endtask

   task automatic write_arm(input logic [11:0] v);
      drain_pipe();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      arm_settings++;
   endtask

   // Random command, biased to the edges now and then.
   task automatic random_command();
      logic [15:0] s, h, w;
      s = 16'($urandom());
      h = 16'($urandom());
      w = 16'($urandom());
      case ($urandom_range(0, 9))
         0: s = 16'sd0;
         1: w = 16'sd0;
         2: h = $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
         3: s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         4: begin
            s = 16'($urandom_range(0, 2000) - 1000);
            w = 16'($urandom_range(0, 400) - 200);
         end
         default: ;
      endcase
      send_command(s, h, w, 1'b1);
   endtask

   initial begin
      logic [11:0] arm_vals[5];
      arm_vals = '{12'd0, 12'd4095, 12'd1, 12'd600, 12'd3000};
      request_total = 0;
      arm_settings = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_data = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands with the reset arm length.
      send_command(16'd0, 16'd0, 16'd0, 1'b0);
      send_command(16'h7fff, 16'd0, 16'd0, 1'b0);
      send_command(16'h8000, 16'd0, 16'd0, 1'b0);
      send_command(16'd1000, 16'sd25736, 16'd0, 1'b0);
      send_command(16'd1000, -16'sd25736, 16'd0, 1'b0);
      send_command(16'd1000, 16'h7fff, 16'd0, 1'b0);
      send_command(16'd1000, 16'h8000, 16'd0, 1'b0);
      send_command(16'd1000, 16'sd12868, 16'd0, 1'b0);
      send_command(16'd1000, -16'sd12868, 16'd0, 1'b0);
      send_command(16'd0, 16'd0, 16'h7fff, 1'b0);
      send_command(16'd0, 16'd0, 16'h8000, 1'b0);
      send_command(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      send_command(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_command(16'hffff, 16'hffff, 16'hffff, 1'b0);
      send_command(16'd500, 16'd6434, 16'd4096, 1'b0);
      send_command(16'd500, 16'd6434, -16'sd4096, 1'b0);

      // Random commands across several arm lengths, both extremes among them.
      for (int p = 0; p < 6; p++) begin
         if (p > 0) write_arm(p <= 5 ? arm_vals[p-1] : 12'($urandom_range(0, 4095)));
         for (int n = 0; n < 85; n++) begin
            if (n == 40) drain_pipe();
            random_command();
         end
      end

      drain_pipe();
      $display("Sent %0d chassis commands under %0d arm length settings,", request_total,
               arm_settings + 1);
      $display("including zero vectors, heading wrap and full-scale yaw.");
      if (fail_count == 0) begin
         $display("swerve_wheel_kinematics_unit test passed");
      end else begin
         $display("swerve_wheel_kinematics_unit test failed");
      end
      $finish;
   end
endmodule

// File: files.f
src/swk_pkg.sv
src/swk_rotate_stage.sv
src/swk_front.sv
src/swk_back.sv
src/swerve_wheel_kinematics_unit.sv
test/swk_checker.sv
test/tb_swerve_wheel_kinematics_unit.sv
